// File: hdl/assert_macros.svh
// assertion macros used by deadzone_event_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dzeq_pkg.sv
// constants and codes of the dead zone event queue
package dzeq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int NUM_IDS     = 512;

    localparam int ID_W    = 9;
    localparam int STATE_W = 16;
    localparam int DZ_W    = 15;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam int QA_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int DZ_AW   = $clog2(NUM_IDS);
    localparam int STORE_W = ID_W + STATE_W;

    localparam int IN_DATA_W  = ((ID_W + STATE_W + DZ_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ID_W + STATE_W + CNT_W + 7) / 8) * 8;

    // dead zones at or below this raw value leave the state as is
    localparam logic [DZ_W-1:0]    DZ_MIN_RAW = DZ_W'(32);
    localparam logic [STATE_W-1:0] ONE_Q15    = 16'h8000;
    localparam logic [STATE_W-1:0] POS_MAX    = 16'h7fff;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: hdl/deadzone_event_queue.sv
// a word is accepted only while idle, then passes the read, condition and finishing
// states, a rescaled push the bit-serial restoring divider too before finishing;
// one word at a time: the next is taken once the result is in the output register
// reset: synchronous, active low; afterwards a clearing pass writes the dead zone
// table one entry a cycle (all NUM_IDS entries, 512 here) with s_axis_tready low
`include "assert_macros.svh"

module deadzone_event_queue import dzeq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // input_id, event_state, deadzone_value
    input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // popped_id, popped_state, queued_count
    output logic [STAT_W-1:0]     m_axis_tuser   // status
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_COND  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_fsm;

    t_fsm r_fsm, n_fsm;

    // latched input word
    logic [CMD_W-1:0]   r_cmd;
    logic [ID_W-1:0]    r_id;
    logic [STATE_W-1:0] r_state;
    logic [DZ_W-1:0]    r_dzv;

    // queue bookkeeping
    logic [QA_W-1:0]  r_head, r_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [DZ_AW-1:0] r_clr_idx;

    // memories
    logic [STORE_W-1:0] r_store [QUEUE_DEPTH];
    logic [DZ_W-1:0]    r_dz_mem [NUM_IDS];
    logic [STORE_W-1:0] r_store_rd;
    logic [DZ_W-1:0]    r_dz_rd;

    // result and divider
    logic [STAT_W-1:0]  r_status;
    logic [ID_W-1:0]    r_pid;
    logic [STATE_W-1:0] r_val;
    logic [STATE_W-1:0] r_rem, r_quo, r_div;
    logic [3:0]         r_step;
    logic               r_neg;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [STAT_W-1:0]     r_m_user;

    logic               s_fire, out_free, done_fire, clearing;
    logic               id_ok, push_ok, pop_ok;
    logic [DZ_W-1:0]    dz_eff;
    logic [STATE_W-1:0] mag, diff, divisor;
    logic [STATE_W:0]   trial;
    logic               trial_ge;
    logic [STATE_W-1:0] n_rem, n_quo, quo_val;
    logic               store_we, dz_we;
    logic [DZ_AW-1:0]   dz_waddr;
    logic [DZ_W-1:0]    dz_wdata;
    logic [ID_W-1:0]    out_id;
    logic [STATE_W-1:0] out_state;

    assign s_axis_tready = (r_fsm == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign done_fire     = (r_fsm == S_DONE) && out_free;
    assign clearing      = (r_fsm == S_CLEAR);

    assign id_ok   = 32'(r_id) < 32'(NUM_IDS);
    assign push_ok = (r_cmd == CMD_PUSH) && (r_status == ST_OK);
    assign pop_ok  = (r_cmd == CMD_POP) && (r_status == ST_OK);

    // dead zone conditioning front end
    assign dz_eff  = id_ok ? r_dz_rd : '0;
    assign mag     = r_state[STATE_W-1] ? (~r_state + 16'd1) : r_state;
    assign diff    = mag - {1'b0, dz_eff};
    assign divisor = ONE_Q15 - {1'b0, dz_eff};

    // one restoring division step per cycle
    assign trial    = {r_rem, r_quo[STATE_W-1]};
    assign trial_ge = trial >= {1'b0, r_div};
    assign n_rem    = trial_ge ? STATE_W'(trial - {1'b0, r_div}) : trial[STATE_W-1:0];
    assign n_quo    = {r_quo[STATE_W-2:0], trial_ge};

    always_comb begin
        if (r_neg) begin
            quo_val = (n_quo > ONE_Q15) ? ONE_Q15 : (~n_quo + 16'd1);
        end else begin
            quo_val = n_quo[STATE_W-1] ? POS_MAX : n_quo;
        end
    end

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign store_we = done_fire && push_ok;
    assign dz_we    = clearing || (done_fire && (r_cmd == CMD_SET) && id_ok);
    assign dz_waddr = clearing ? r_clr_idx : DZ_AW'(r_id);
    assign dz_wdata = clearing ? '0 : r_dzv;

    assign out_id    = pop_ok ? r_pid : '0;
    assign out_state = pop_ok ? r_val : '0;

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_CLEAR: begin
                if (r_clr_idx == DZ_AW'(NUM_IDS - 1)) n_fsm = S_IDLE;
            end
            S_IDLE: begin
                if (s_fire) n_fsm = S_READ;
            end
            S_READ: n_fsm = S_COND;
            S_COND: begin
                if ((r_cmd == CMD_PUSH) && (r_count != CNT_W'(QUEUE_DEPTH)) &&
                    (dz_eff > DZ_MIN_RAW) && (mag > {1'b0, dz_eff})) begin
                    n_fsm = S_DIV;
                end else begin
                    n_fsm = S_DONE;
                end
            end
            S_DIV: begin
                if (r_step == 4'd0) n_fsm = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_fsm = S_IDLE;
            end
            default: n_fsm = S_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_CLEAR;
            r_clr_idx <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (clearing) r_clr_idx <= r_clr_idx + DZ_AW'(1);
            if (done_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (done_fire) begin
                r_count   <= n_count;
                if (push_ok) begin
                    r_tail <= (r_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QA_W'(1);
                end
                if (pop_ok) begin
                    r_head <= (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + QA_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_cmd   <= s_axis_tuser;
            r_id    <= s_axis_tdata[ID_W-1:0];
            r_state <= s_axis_tdata[ID_W+STATE_W-1:ID_W];
            r_dzv   <= s_axis_tdata[ID_W+STATE_W+DZ_W-1:ID_W+STATE_W];
        end
        if (r_fsm == S_COND) begin
            r_pid    <= r_store_rd[STORE_W-1:STATE_W];
            r_neg    <= r_state[STATE_W-1];
            r_div    <= divisor;
            r_rem    <= {1'b0, diff[STATE_W-1:1]};
            r_quo    <= {diff[0], {(STATE_W-1){1'b0}}};
            r_step   <= 4'd15;
            case (r_cmd)
                CMD_PUSH: begin
                    if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                        r_status <= ST_FULL;
                        r_val    <= r_store_rd[STATE_W-1:0];
                    end else if (dz_eff <= DZ_MIN_RAW) begin
                        r_status <= ST_OK;
                        r_val    <= r_state;
                    end else begin
                        // inside the dead zone; overwritten by the divider otherwise
                        r_status <= ST_OK;
                        r_val    <= '0;
                    end
                end
                CMD_POP: begin
                    r_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                    r_val    <= r_store_rd[STATE_W-1:0];
                end
                default: begin
                    r_status <= ST_OK;
                    r_val    <= r_store_rd[STATE_W-1:0];
                end
            endcase
        end
        if (r_fsm == S_DIV) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_step <= r_step - 4'd1;
            if (r_step == 4'd0) r_val <= quo_val;
        end
        if (done_fire) begin
            r_m_user <= r_status;
            r_m_data <= OUT_DATA_W'({n_count, out_state, out_id});
        end
    end

    // event ring
    always_ff @(posedge i_clk) begin
        if (store_we) r_store[r_tail] <= {r_id, r_val};
        r_store_rd <= r_store[r_head];
    end

    // dead zone table
    always_ff @(posedge i_clk) begin
        if (dz_we) r_dz_mem[dz_waddr] <= dz_wdata;
        r_dz_rd <= r_dz_mem[DZ_AW'(r_id)];
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `ASSERT_IMPL(a_ring_ptrs, i_clk, i_rst_n, (r_count == '0 || r_count == CNT_W'(QUEUE_DEPTH)), (r_head == r_tail), "ring pointers disagree with count")
    `ASSERT_IMPL(a_div_push, i_clk, i_rst_n, (r_fsm == S_DIV), (r_cmd == CMD_PUSH && r_status == ST_OK), "divider running for a word that is no accepted push")
    `ASSERT_IMPL(a_out_src, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(r_fsm == S_DONE), "result word appeared outside the finishing state")
    `ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, (r_count <= CNT_W'(QUEUE_DEPTH)), "queue count beyond depth")

endmodule

// File: tb/dzeq_result_check.sv
// predictor and comparator watching both stream channels of the dead zone event queue
`timescale 1ns / 100ps

module dzeq_result_check import dzeq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,    // input_id, event_state, deadzone_value
    input  logic [CMD_W-1:0]      i_in_cmd,     // cmd
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,   // popped_id, popped_state, queued_count
    input  logic [STAT_W-1:0]     i_out_status, // status
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_words_checked,
    output int                    o_full_refusals,
    output int                    o_empty_pops
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] state;
        logic [CNT_W-1:0]   count;
    } queue_result_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] state;
    } queued_event_t;

    logic [DZ_W-1:0] dz_table [NUM_IDS];
    queued_event_t   event_fifo [$];
    queue_result_t   awaited_results [$];

    int fail_count    = 0;
    int words_checked = 0;
    int full_refusals = 0;
    int empty_pops    = 0;

    // dead zone removal and rescale of a raw q1.15 state
    function automatic logic [STATE_W-1:0] condition_state(logic [STATE_W-1:0] raw,
                                                           logic [DZ_W-1:0] dz);
        int unsigned mag;
        int unsigned quo;
        if (dz <= DZ_MIN_RAW)
            return raw;
        mag = raw[STATE_W-1] ? (32'h1_0000 - raw) : raw;
        if (mag <= dz)
            return '0;
        quo = ((mag - dz) * 32'd32768) / (32'd32768 - dz);
        if (raw[STATE_W-1]) begin
            if (quo > 32'd32768)
                quo = 32'd32768;
            return STATE_W'(32'h1_0000 - quo);
        end
        if (quo > 32'd32767)
            quo = 32'd32767;
        return STATE_W'(quo);
    endfunction

    // applies one command to the shadow queue and returns the word it should produce
    function automatic queue_result_t run_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                                  logic [STATE_W-1:0] state,
                                                  logic [DZ_W-1:0] dz);
        queue_result_t r;
        queued_event_t ev;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (event_fifo.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ev.id    = id;
                    ev.state = condition_state(state, dz_table[id]);
                    event_fifo.push_back(ev);
                end
            end
            CMD_POP: begin
                if (event_fifo.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ev      = event_fifo.pop_front();
                    r.id    = ev.id;
                    r.state = ev.state;
                end
            end
            CMD_SET: begin
                if (id < NUM_IDS)
                    dz_table[id] = dz;
            end
            default: ;
        endcase
        r.count = CNT_W'(event_fifo.size());
        return r;
    endfunction

    task automatic check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, label,
                     want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        queue_result_t got;
        queue_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IDS; i++)
                dz_table[i] = '0;
            event_fifo.delete();
            awaited_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(run_command(i_in_cmd, i_in_data[ID_W-1:0],
                                                      i_in_data[ID_W +: STATE_W],
                                                      i_in_data[ID_W+STATE_W +: DZ_W]));
            if (i_out_valid && i_out_ready) begin
                got.status = i_out_status;
                got.id     = i_out_data[ID_W-1:0];
                got.state  = i_out_data[ID_W +: STATE_W];
                got.count  = i_out_data[ID_W+STATE_W +: CNT_W];
                if (awaited_results.size() == 0) begin
                    $display("%0t: result word with none awaited, expected nothing, actual 0x%0h",
                             $realtime, got);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("popped_id", want.id, got.id);
                    check_field("popped_state", want.state, got.state);
                    check_field("queued_count", want.count, got.count);
                    words_checked++;
                    if (want.status == ST_FULL)
                        full_refusals++;
                    if (want.status == ST_EMPTY)
                        empty_pops++;
                end
            end
        end
        o_pending       <= awaited_results.size();
        o_fail_count    <= fail_count;
        o_words_checked <= words_checked;
        o_full_refusals <= full_refusals;
        o_empty_pops    <= empty_pops;
    end

endmodule

// File: tb/tb_deadzone_event_queue.sv
// stimulus and verdict for the dead zone event queue, checked by dzeq_result_check
`timescale 1ns / 100ps

module tb_deadzone_event_queue;
    import dzeq_pkg::*;

    // a command code the block must treat as a no-op
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int MIX_WORDS    = 120;
    localparam int TAIL_WORDS   = 120;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [CMD_W-1:0]      s_user  = CMD_PUSH;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic [STAT_W-1:0]     m_user;

    int fail_count;
    int pending_words;
    int words_checked;
    int full_refusals;
    int empty_pops;

    int sender_idle_pct = 8;
    int recv_idle_pct   = 56;
    int fill_level      = 0;
    int push_count      = 0;
    int pop_count       = 0;
    int set_count       = 0;
    int other_count     = 0;
    int cycle_count     = 0;
    logic hold_request  = 1'b0;
    logic hold_active   = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    deadzone_event_queue i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    dzeq_result_check u_result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (s_valid),
        .i_in_ready      (s_ready),
        .i_in_data       (s_data),
        .i_in_cmd        (s_user),
        .i_out_valid     (m_valid),
        .i_out_ready     (m_ready),
        .i_out_data      (m_data),
        .i_out_status    (m_user),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_words_checked (words_checked),
        .o_full_refusals (full_refusals),
        .o_empty_pops    (empty_pops)
    );

    always @(negedge clk) begin
        if (hold_active)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall so the block backs up into its input
    initial begin
        wait (hold_request);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still awaited", cycle_count,
                     pending_words);
            $display("tb_deadzone_event_queue: FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [STATE_W-1:0] st, input logic [DZ_W-1:0] dz);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {dz, st, id};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        case (cmd)
            CMD_PUSH: begin
                push_count++;
                if (fill_level < QUEUE_DEPTH)
                    fill_level++;
            end
            CMD_POP: begin
                pop_count++;
                if (fill_level > 0)
                    fill_level--;
            end
            CMD_SET: set_count++;
            default: other_count++;
        endcase
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        int pick;
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] st;
        logic [DZ_W-1:0]    dz;
        pick = $urandom_range(99);
        if (pick < push_pct)
            cmd = CMD_PUSH;
        else if (pick < push_pct + pop_pct)
            cmd = CMD_POP;
        else
            cmd = CMD_SET;
        // mostly a few ids so that stored dead zones get used by pushes
        if ($urandom_range(4) == 0)
            id = ID_W'($urandom_range(NUM_IDS - 1));
        else
            id = ID_W'($urandom_range(15));
        case ($urandom_range(3))
            0: st = STATE_W'($urandom);
            1: begin
                st = STATE_W'($urandom_range(600));
                if ($urandom_range(1))
                    st = -st;
            end
            2: begin
                case ($urandom_range(4))
                    0: st = 16'h7fff;
                    1: st = 16'h8000;
                    2: st = 16'h0000;
                    3: st = 16'hffff;
                    default: st = 16'h0001;
                endcase
            end
            default: st = STATE_W'($urandom);
        endcase
        case ($urandom_range(4))
            0: dz = DZ_W'($urandom_range(DZ_MIN_RAW));
            1: dz = DZ_W'($urandom_range(1000, DZ_MIN_RAW + 1));
            2: dz = DZ_W'($urandom_range(32767, 1001));
            3: dz = 15'h7fff;
            default: dz = '0;
        endcase
        send_word(cmd, id, st, dz);
    endtask

    initial begin
        $timeformat(-9, 1, " ns", 0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, unknown command, extremes and dead zone edges
        send_word(CMD_POP, 9'd0, 16'h0000, 15'd0);
        send_word(CMD_NONE, 9'd5, 16'h1234, 15'd100);
        send_word(CMD_PUSH, 9'd0, 16'h8000, 15'd0);
        send_word(CMD_PUSH, 9'd511, 16'h7fff, 15'h7fff);
        send_word(CMD_SET, 9'd1, 16'h0000, DZ_MIN_RAW);
        send_word(CMD_PUSH, 9'd1, 16'h8000, 15'd0);
        send_word(CMD_SET, 9'd2, 16'h0000, DZ_MIN_RAW + 15'd1);
        send_word(CMD_PUSH, 9'd2, 16'd33, 15'd0);
        send_word(CMD_PUSH, 9'd2, 16'hffdf, 15'd0);
        send_word(CMD_PUSH, 9'd2, 16'd34, 15'd0);
        send_word(CMD_PUSH, 9'd2, 16'h8000, 15'd0);
        send_word(CMD_PUSH, 9'd2, 16'h7fff, 15'd0);
        send_word(CMD_SET, 9'd3, 16'hffff, 15'h7fff);
        send_word(CMD_PUSH, 9'd3, 16'h8000, 15'd0);
        send_word(CMD_PUSH, 9'd3, 16'h7fff, 15'd0);
        send_word(CMD_SET, 9'd511, 16'h0000, 15'd16384);
        send_word(CMD_PUSH, 9'd511, 16'hc000, 15'd0);
        send_word(CMD_PUSH, 9'd511, 16'h6000, 15'd0);
        repeat (5)
            send_word(CMD_POP, 9'h1ff, 16'hffff, 15'h7fff);

        for (int n = 0; n < MIX_WORDS; n++) begin
            if (n == 40)
                hold_request = 1'b1;
            send_random(40, 40);
        end

        // fill the ring up, then knock on it while full
        sender_idle_pct = 56;
        recv_idle_pct   = 8;
        while (fill_level < QUEUE_DEPTH)
            send_random(97, 1);
        repeat (12)
            send_random(80, 15);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        repeat (TAIL_WORDS)
            send_random(35, 50);
        @(negedge clk);
        s_valid <= 1'b0;

        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d pushes, %0d pops, %0d dead zone writes, %0d no-ops",
                 push_count + pop_count + set_count + other_count, push_count, pop_count,
                 set_count, other_count);
        $display("%0d result words checked, %0d pushes refused on a full ring, %0d empty pops",
                 words_checked, full_refusals, empty_pops);
        if (fail_count == 0)
            $display("tb_deadzone_event_queue: PASS");
        else
            $display("tb_deadzone_event_queue: FAIL");
        $finish;
    end

endmodule
